@@ hw/rtl/mersenne31_field_alu_defines.svh @@
// Assertion macros used by the checker file.
`ifndef MERSENNE31_FIELD_ALU_DEFINES_SVH
`define MERSENNE31_FIELD_ALU_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define M31_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define M31_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/m31alu_pkg.sv @@
package m31alu_pkg;

  localparam int unsigned FieldW = 31;
  localparam int unsigned ExpW   = 32;
  localparam int unsigned ProdW  = 2 * FieldW;

  localparam logic [FieldW-1:0] Prime  = {FieldW{1'b1}};
  localparam logic [FieldW-1:0] One    = {{(FieldW-1){1'b0}}, 1'b1};
  localparam logic [ExpW-1:0]   InvExp = {1'b0, Prime} - 32'd2;

  typedef enum logic [2:0] {
    ACT_ADD = 3'd0,
    ACT_SUB = 3'd1,
    ACT_NEG = 3'd2,
    ACT_MUL = 3'd3,
    ACT_DIV = 3'd4,
    ACT_POW = 3'd5,
    ACT_INV = 3'd6
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_LOOP,
    ST_MUL_ACC,
    ST_MUL_SQ,
    ST_MUL_FIN,
    ST_RED_FIN,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    MSEL_ACC_SQ,
    MSEL_SQ_SQ,
    MSEL_A_B,
    MSEL_A_ACC
  } mul_sel_e;

  typedef enum logic [1:0] {
    DST_NONE,
    DST_ACC,
    DST_SQ
  } dst_e;

  typedef enum logic {
    BASE_A,
    BASE_B
  } base_sel_e;

  typedef enum logic {
    EXP_RAW,
    EXP_INV
  } exp_sel_e;

  typedef enum logic [2:0] {
    RES_ADD,
    RES_SUB,
    RES_NEG,
    RES_ACC,
    RES_ZERO
  } res_sel_e;

  typedef struct packed {
    logic      load;
    logic      pow_init;
    base_sel_e base_sel;
    exp_sel_e  exp_sel;
    logic      mul_go;
    mul_sel_e  mul_sel;
    dst_e      mul_dst;
    logic      exp_shift;
    res_sel_e  res_sel;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic exp_zero;
    logic exp_lsb;
  } status_t;

endpackage

@@ hw/rtl/m31alu_dp.sv @@
module m31alu_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  m31alu_pkg::cmd_t                  cmd_i,
  output m31alu_pkg::status_t               status_o,
  input  logic [m31alu_pkg::FieldW-1:0]     operand_a_i,
  input  logic [m31alu_pkg::ExpW-1:0]       operand_b_i,
  output logic [m31alu_pkg::FieldW-1:0]     result_o
);

  // Bring a value below twice the prime into canonical range.
  function automatic logic [m31alu_pkg::FieldW-1:0] canon(
    input logic [m31alu_pkg::FieldW:0] s
  );
    logic [m31alu_pkg::FieldW:0] d;
    d = s - {1'b0, m31alu_pkg::Prime};
    return (s >= {1'b0, m31alu_pkg::Prime}) ? d[m31alu_pkg::FieldW-1:0]
                                            : s[m31alu_pkg::FieldW-1:0];
  endfunction

  logic [m31alu_pkg::FieldW-1:0] a_q, a_d;
  logic [m31alu_pkg::ExpW-1:0]   braw_q;
  logic [m31alu_pkg::FieldW-1:0] acc_q, acc_d;
  logic [m31alu_pkg::FieldW-1:0] sq_q, sq_d;
  logic [m31alu_pkg::ExpW-1:0]   exp_q, exp_d;
  logic [m31alu_pkg::ProdW-1:0]  prod_q, prod_d;
  m31alu_pkg::dst_e              dst_q, dst_d;
  logic [m31alu_pkg::FieldW-1:0] result_q, result_d;

  logic [m31alu_pkg::FieldW-1:0] b_f;
  logic [m31alu_pkg::FieldW-1:0] op_x, op_y;
  logic [m31alu_pkg::FieldW:0]   t1, t2;
  logic [m31alu_pkg::FieldW-1:0] red;
  logic [m31alu_pkg::FieldW-1:0] sum_add, sum_sub, neg_a;

  assign a_d = (operand_a_i == m31alu_pkg::Prime) ? '0 : operand_a_i;

  assign b_f = canon({{m31alu_pkg::FieldW{1'b0}}, braw_q[m31alu_pkg::ExpW-1]}
                     + {1'b0, braw_q[m31alu_pkg::FieldW-1:0]});

  always_comb begin
    case (cmd_i.mul_sel)
      m31alu_pkg::MSEL_ACC_SQ: begin
        op_x = acc_q;
        op_y = sq_q;
      end
      m31alu_pkg::MSEL_SQ_SQ: begin
        op_x = sq_q;
        op_y = sq_q;
      end
      m31alu_pkg::MSEL_A_B: begin
        op_x = a_q;
        op_y = b_f;
      end
      default: begin
        op_x = a_q;
        op_y = acc_q;
      end
    endcase
  end

  assign prod_d = {{m31alu_pkg::FieldW{1'b0}}, op_x} * {{m31alu_pkg::FieldW{1'b0}}, op_y};
  assign dst_d  = cmd_i.mul_go ? cmd_i.mul_dst : m31alu_pkg::DST_NONE;

  // Fold the high half onto the low half twice, since 2^31 is one mod p.
  assign t1  = {1'b0, prod_q[m31alu_pkg::FieldW-1:0]}
             + {1'b0, prod_q[m31alu_pkg::ProdW-1:m31alu_pkg::FieldW]};
  assign t2  = {1'b0, t1[m31alu_pkg::FieldW-1:0]}
             + {{m31alu_pkg::FieldW{1'b0}}, t1[m31alu_pkg::FieldW]};
  assign red = canon(t2);

  assign sum_add = canon({1'b0, a_q} + {1'b0, b_f});
  assign sum_sub = canon({1'b0, a_q} + {1'b0, m31alu_pkg::Prime - b_f});
  assign neg_a   = (a_q == '0) ? '0 : m31alu_pkg::Prime - a_q;

  always_comb begin
    acc_d = acc_q;
    sq_d  = sq_q;
    exp_d = exp_q;
    if (cmd_i.pow_init) begin
      acc_d = m31alu_pkg::One;
      sq_d  = (cmd_i.base_sel == m31alu_pkg::BASE_B) ? b_f : a_q;
      exp_d = (cmd_i.exp_sel == m31alu_pkg::EXP_INV) ? m31alu_pkg::InvExp : braw_q;
    end else begin
      if (dst_q == m31alu_pkg::DST_ACC) begin
        acc_d = red;
      end
      if (dst_q == m31alu_pkg::DST_SQ) begin
        sq_d = red;
      end
      if (cmd_i.exp_shift) begin
        exp_d = exp_q >> 1;
      end
    end
  end

  always_comb begin
    result_d = result_q;
    if (cmd_i.out_load) begin
      case (cmd_i.res_sel)
        m31alu_pkg::RES_ADD: result_d = sum_add;
        m31alu_pkg::RES_SUB: result_d = sum_sub;
        m31alu_pkg::RES_NEG: result_d = neg_a;
        m31alu_pkg::RES_ACC: result_d = acc_q;
        default:             result_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dst_q <= m31alu_pkg::DST_NONE;
    end else begin
      dst_q <= dst_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q    <= a_d;
      braw_q <= operand_b_i;
    end
    acc_q    <= acc_d;
    sq_q     <= sq_d;
    exp_q    <= exp_d;
    prod_q   <= prod_d;
    result_q <= result_d;
  end

  assign status_o.exp_zero = (exp_q == '0);
  assign status_o.exp_lsb  = exp_q[0];
  assign result_o          = result_q;

endmodule

@@ hw/rtl/m31alu_ctrl.sv @@
module m31alu_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          action_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  m31alu_pkg::status_t status_i,
  output m31alu_pkg::cmd_t    cmd_o
);

  m31alu_pkg::state_e  state_q, state_d;
  m31alu_pkg::action_e act_q, act_d;
  logic                out_valid_q, out_valid_d;
  logic                accept;

  assign in_ready_o = (state_q == m31alu_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign act_d      = accept ? m31alu_pkg::action_e'(action_i) : act_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      m31alu_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = m31alu_pkg::ST_SETUP;
        end
      end
      m31alu_pkg::ST_SETUP: begin
        unique case (act_q) inside
          m31alu_pkg::ACT_MUL: state_d = m31alu_pkg::ST_MUL_FIN;
          m31alu_pkg::ACT_DIV, m31alu_pkg::ACT_POW, m31alu_pkg::ACT_INV:
            state_d = m31alu_pkg::ST_LOOP;
          default: state_d = m31alu_pkg::ST_DONE;
        endcase
      end
      m31alu_pkg::ST_LOOP: begin
        if (status_i.exp_zero) begin
          state_d = (act_q == m31alu_pkg::ACT_DIV) ? m31alu_pkg::ST_MUL_FIN
                                                   : m31alu_pkg::ST_DONE;
        end else if (status_i.exp_lsb) begin
          state_d = m31alu_pkg::ST_MUL_ACC;
        end else begin
          state_d = m31alu_pkg::ST_MUL_SQ;
        end
      end
      m31alu_pkg::ST_MUL_ACC: state_d = m31alu_pkg::ST_MUL_SQ;
      m31alu_pkg::ST_MUL_SQ:  state_d = m31alu_pkg::ST_LOOP;
      m31alu_pkg::ST_MUL_FIN: state_d = m31alu_pkg::ST_RED_FIN;
      m31alu_pkg::ST_RED_FIN: state_d = m31alu_pkg::ST_DONE;
      m31alu_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = m31alu_pkg::ST_IDLE;
        end
      end
      default: state_d = m31alu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.base_sel  = m31alu_pkg::BASE_A;
    cmd_o.exp_sel   = m31alu_pkg::EXP_RAW;
    cmd_o.mul_sel   = m31alu_pkg::MSEL_ACC_SQ;
    cmd_o.mul_dst   = m31alu_pkg::DST_NONE;
    cmd_o.res_sel   = m31alu_pkg::RES_ZERO;
    unique case (state_q)
      m31alu_pkg::ST_IDLE: begin
        cmd_o.load = in_valid_i;
      end
      m31alu_pkg::ST_SETUP: begin
        cmd_o.pow_init = (act_q == m31alu_pkg::ACT_DIV) || (act_q == m31alu_pkg::ACT_POW)
                      || (act_q == m31alu_pkg::ACT_INV);
        cmd_o.base_sel = (act_q == m31alu_pkg::ACT_DIV) ? m31alu_pkg::BASE_B
                                                        : m31alu_pkg::BASE_A;
        cmd_o.exp_sel  = (act_q == m31alu_pkg::ACT_POW) ? m31alu_pkg::EXP_RAW
                                                        : m31alu_pkg::EXP_INV;
      end
      m31alu_pkg::ST_MUL_ACC: begin
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_sel = m31alu_pkg::MSEL_ACC_SQ;
        cmd_o.mul_dst = m31alu_pkg::DST_ACC;
      end
      m31alu_pkg::ST_MUL_SQ: begin
        cmd_o.mul_go    = 1'b1;
        cmd_o.mul_sel   = m31alu_pkg::MSEL_SQ_SQ;
        cmd_o.mul_dst   = m31alu_pkg::DST_SQ;
        cmd_o.exp_shift = 1'b1;
      end
      m31alu_pkg::ST_MUL_FIN: begin
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_sel = (act_q == m31alu_pkg::ACT_DIV) ? m31alu_pkg::MSEL_A_ACC
                                                       : m31alu_pkg::MSEL_A_B;
        cmd_o.mul_dst = m31alu_pkg::DST_ACC;
      end
      m31alu_pkg::ST_DONE: begin
        cmd_o.out_load = !out_valid_q || out_ready_i;
        unique case (act_q) inside
          m31alu_pkg::ACT_ADD: cmd_o.res_sel = m31alu_pkg::RES_ADD;
          m31alu_pkg::ACT_SUB: cmd_o.res_sel = m31alu_pkg::RES_SUB;
          m31alu_pkg::ACT_NEG: cmd_o.res_sel = m31alu_pkg::RES_NEG;
          m31alu_pkg::ACT_MUL, m31alu_pkg::ACT_DIV, m31alu_pkg::ACT_POW,
          m31alu_pkg::ACT_INV: cmd_o.res_sel = m31alu_pkg::RES_ACC;
          default:             cmd_o.res_sel = m31alu_pkg::RES_ZERO;
        endcase
      end
      default: begin
      end
    endcase
  end

  assign out_valid_d = cmd_o.out_load || (out_valid_q && !out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= m31alu_pkg::ST_IDLE;
      act_q       <= m31alu_pkg::ACT_ADD;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      act_q       <= act_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ hw/rtl/mersenne31_field_alu.sv @@
// Arithmetic unit for the field modulo p = 2^31-1: add, subtract, negate, multiply,
// divide, power and invert, one canonical 31-bit result per input word. Words are
// taken one at a time; the next word is accepted once the current result sits in
// the output register, even if that result has not been taken yet. Add, subtract,
// negate and unused action codes go from setup straight to the result stage;
// multiply adds one product and its fold. Power, invert and divide run
// square-and-multiply on one shared 31x31 multiplier whose product is registered
// and then folded mod p in the following cycle: per exponent bit up to the highest
// set bit, a multiply into the accumulator if the bit is set, then a squaring; divide
// then multiplies operand a by the inverse. Division or inversion of zero gives 0.
module mersenne31_field_alu (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [2:0]                    action_i,
  input  logic [m31alu_pkg::FieldW-1:0] operand_a_i,
  input  logic [m31alu_pkg::ExpW-1:0]   operand_b_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [m31alu_pkg::FieldW-1:0] result_o
);

  m31alu_pkg::cmd_t    cmd;
  m31alu_pkg::status_t status;

  m31alu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  m31alu_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .result_o    (result_o)
  );

endmodule

@@ hw/rtl/m31alu_checker.sv @@
`include "mersenne31_field_alu_defines.svh"

module m31alu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [2:0]  action_i,
  input logic [30:0] operand_a_i,
  input logic [31:0] operand_b_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [30:0] result_o
);

  `M31_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(result_o), "result word dropped or changed while stalled")
  `M31_ASSERT_NOW(a_out_canon, out_valid_o, result_o != 31'h7FFFFFFF, "result word not canonical")
  `M31_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "input word accepted while busy")

endmodule

bind mersenne31_field_alu m31alu_checker u_checker (.*);

@@ verif/tb_mersenne31_field_alu.sv @@
`timescale 1ns / 100ps

module tb_mersenne31_field_alu;

  localparam int unsigned FieldW = m31alu_pkg::FieldW;
  localparam int unsigned ExpW   = m31alu_pkg::ExpW;
  localparam int unsigned ProdW  = m31alu_pkg::ProdW;

  localparam logic [FieldW-1:0] Prime  = m31alu_pkg::Prime;
  localparam logic [FieldW-1:0] One    = m31alu_pkg::One;
  localparam logic [ExpW-1:0]   InvExp = m31alu_pkg::InvExp;

  localparam logic [2:0]  ActUnused   = 3'd7;
  localparam int unsigned StuckLimit  = 5000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 120;
  localparam int unsigned IdlePct     = 28;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic [2:0]        action      = '0;
  logic [FieldW-1:0] operand_a   = '0;
  logic [ExpW-1:0]   operand_b   = '0;
  logic              out_ready   = 1'b0;
  logic              in_ready;
  logic              out_valid;
  logic [FieldW-1:0] result;

  logic [FieldW-1:0] field_results_due[$];
  int unsigned       mismatch_count = 0;
  int unsigned       stuck_cycles   = 0;
  int unsigned       hold_left      = 0;
  bit                gap_en         = 1'b1;
  bit                stall_en       = 1'b1;

  mersenne31_field_alu dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .action_i    (action),
    .operand_a_i (operand_a),
    .operand_b_i (operand_b),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .result_o    (result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [FieldW-1:0] fold_word(logic [ExpW-1:0] x);
    logic [ExpW-1:0] s;
    s = {31'd0, x[31]} + {1'b0, x[30:0]};
    if (s >= {1'b0, Prime}) s = s - {1'b0, Prime};
    return s[FieldW-1:0];
  endfunction

  function automatic logic [FieldW-1:0] field_mul(logic [FieldW-1:0] x, logic [FieldW-1:0] y);
    logic [ProdW-1:0] prod;
    logic [32:0]      t;
    prod = {31'd0, x} * {31'd0, y};
    t = {2'd0, prod[30:0]} + {2'd0, prod[61:31]};
    t = {2'd0, t[30:0]} + {31'd0, t[32:31]};
    if (t >= {2'd0, Prime}) t = t - {2'd0, Prime};
    return t[FieldW-1:0];
  endfunction

  function automatic logic [FieldW-1:0] field_pow(logic [FieldW-1:0] base, logic [ExpW-1:0] e);
    logic [FieldW-1:0] acc;
    logic [FieldW-1:0] sq;
    acc = One;
    sq = base;
    for (int i = 0; i < ExpW; i++) begin
      if (e[i]) acc = field_mul(acc, sq);
      sq = field_mul(sq, sq);
    end
    return acc;
  endfunction

  function automatic logic [FieldW-1:0] field_alu_predict(logic [2:0] act, logic [FieldW-1:0] a,
                                                          logic [ExpW-1:0] b);
    logic [FieldW-1:0] ac;
    logic [FieldW-1:0] bc;
    ac = fold_word({1'b0, a});
    bc = fold_word(b);
    case (act)
      m31alu_pkg::ACT_ADD: return fold_word({1'b0, ac} + {1'b0, bc});
      m31alu_pkg::ACT_SUB: return fold_word({1'b0, ac} + ({1'b0, Prime} - {1'b0, bc}));
      m31alu_pkg::ACT_NEG: return fold_word({1'b0, Prime} - {1'b0, ac});
      m31alu_pkg::ACT_MUL: return field_mul(ac, bc);
      m31alu_pkg::ACT_DIV: return field_mul(ac, field_pow(bc, InvExp));
      m31alu_pkg::ACT_POW: return field_pow(ac, b);
      m31alu_pkg::ACT_INV: return field_pow(ac, InvExp);
      default: return '0;
    endcase
  endfunction

  // Call right after a rising edge; returns in the step of acceptance.
  task automatic send_word(logic [2:0] act, logic [FieldW-1:0] a, logic [ExpW-1:0] b);
    int unsigned gap;
    if (gap_en && $urandom_range(99) < IdlePct) begin
      gap = $urandom_range(6, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    field_results_due.push_back(field_alu_predict(act, a, b));
  endtask

  task automatic test_corner_operands();
    send_word(m31alu_pkg::ACT_ADD, Prime - 1, {1'b0, Prime} - 1);
    send_word(m31alu_pkg::ACT_ADD, '0, '1);
    send_word(m31alu_pkg::ACT_ADD, Prime, 32'd5);
    send_word(m31alu_pkg::ACT_SUB, '0, {1'b0, Prime} - 1);
    send_word(m31alu_pkg::ACT_SUB, 31'd5, {1'b0, Prime});
    send_word(m31alu_pkg::ACT_SUB, Prime, '1);
    send_word(m31alu_pkg::ACT_NEG, '0, '0);
    send_word(m31alu_pkg::ACT_NEG, Prime - 1, '1);
    send_word(m31alu_pkg::ACT_NEG, Prime, '0);
    send_word(m31alu_pkg::ACT_MUL, Prime - 1, {1'b0, Prime} - 1);
    send_word(m31alu_pkg::ACT_MUL, 31'h4000_0000, '1);
    send_word(m31alu_pkg::ACT_MUL, '0, 32'hdead_beef);
    send_word(m31alu_pkg::ACT_DIV, 31'd12345, '0);
    send_word(m31alu_pkg::ACT_DIV, 31'd777, {1'b0, Prime});
    send_word(m31alu_pkg::ACT_DIV, Prime - 1, {1'b0, Prime} - 1);
    send_word(m31alu_pkg::ACT_DIV, 31'd12345, 32'd678);
    send_word(m31alu_pkg::ACT_POW, '0, '0);
    send_word(m31alu_pkg::ACT_POW, 31'd7, '0);
    send_word(m31alu_pkg::ACT_POW, Prime - 1, '1);
    send_word(m31alu_pkg::ACT_POW, 31'd3, 32'h8000_0000);
    send_word(m31alu_pkg::ACT_INV, '0, '0);
    send_word(m31alu_pkg::ACT_INV, One, '0);
    send_word(m31alu_pkg::ACT_INV, Prime - 1, '1);
    send_word(m31alu_pkg::ACT_INV, Prime, 32'd9);
    send_word(ActUnused, 31'h5555_5555, 32'haaaa_aaaa);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_result_backpressure();
    gap_en = 1'b0;
    hold_left <= HoldCycles;
    for (int i = 0; i < 16; i++) begin
      send_word(i[0] ? m31alu_pkg::ACT_POW : m31alu_pkg::ACT_MUL, FieldW'($urandom()),
                $urandom());
    end
    in_valid <= 1'b0;
    @(posedge clk);
    gap_en = 1'b1;
  endtask

  task automatic test_random_words(int unsigned n_words);
    logic [2:0]        act;
    logic [FieldW-1:0] a;
    logic [ExpW-1:0]   b;
    for (int unsigned i = 0; i < n_words; i++) begin
      if (i == n_words / 3) begin
        gap_en = 1'b0;
        stall_en <= 1'b0;
      end
      if (i == n_words / 3 + n_words / 4) begin
        gap_en = 1'b1;
        stall_en <= 1'b1;
      end
      act = ($urandom_range(39) == 0) ? ActUnused : 3'($urandom_range(6));
      case ($urandom_range(9))
        0:       a = '0;
        1:       a = One;
        2:       a = Prime - 1;
        3:       a = Prime;
        default: a = FieldW'($urandom());
      endcase
      case ($urandom_range(11))
        0:       b = '0;
        1:       b = 32'd1;
        2:       b = {1'b0, Prime};
        3:       b = {1'b0, Prime} - 1;
        4:       b = '1;
        5:       b = 32'($urandom_range(15));
        default: b = $urandom();
      endcase
      send_word(act, a, b);
    end
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (stall_en && $urandom_range(99) < IdlePct) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (field_results_due.size() == 0) begin
        if (mismatch_count < 10) $display("unexpected result word: actual %h", result);
        mismatch_count++;
      end else if (result !== field_results_due[0]) begin
        if (mismatch_count < 10) begin
          $display("result mismatch: expected %h actual %h", field_results_due[0], result);
        end
        mismatch_count++;
        void'(field_results_due.pop_front());
      end else begin
        void'(field_results_due.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corner_operands();
    test_result_backpressure();
    test_random_words(900);
    while (field_results_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
